// ----- rtl/ttt_pkg.sv -----
// Package: types and constants for the transaction tracker.
`default_nettype none
package ttt_pkg;
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS = 16;
    localparam logic [7:0] TIMEOUT_RST = 8'd8;
    localparam logic [7:0] MARGIN_RST = 8'd4;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 1'b1;

    localparam logic [1:0] MODE_OPEN = 2'd0;
    localparam logic [1:0] MODE_REPLY = 2'd1;
    localparam logic [1:0] MODE_ERROR = 2'd2;
    localparam logic [1:0] MODE_TICK = 2'd3;

    localparam logic [2:0] K_OPENED = 3'd0;
    localparam logic [2:0] K_REJECT = 3'd1;
    localparam logic [2:0] K_UNTRACKED = 3'd2;
    localparam logic [2:0] K_SUCCESS = 3'd3;
    localparam logic [2:0] K_FAILURE = 3'd4;
    localparam logic [2:0] K_FLUSH = 3'd5;
    localparam logic [2:0] K_MATCHED = 3'd6;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] request_id;
        logic [31:0] barrier_id;
        logic [31:0] caller_id;
        logic [63:0] switch_id;
        logic [31:0] reply_id;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] result_switch;
        logic [31:0] result_caller_id;
        logic        last;
    } out_item_t;
endpackage
`default_nettype wire

// ----- rtl/ttt_fifo.sv -----
// Small register queue used between the front and back parts and at the output.
`default_nettype none
module ttt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg;
    logic do_push, do_pop;

    assign full = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (do_pop)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/ttt_engine.sv -----
// Back part: table of transactions, lookup, open, reply and tick scan sequencer.
`default_nettype none
module ttt_engine #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         timeout_ticks,
    input  wire logic [7:0]         margin_ticks,
    input  wire logic               in_empty,
    input  wire ttt_pkg::in_item_t  in_item,
    output logic                    in_pop,
    input  wire logic               out_full,
    output logic                    out_push,
    output logic                    out_close,
    output ttt_pkg::out_item_t      out_item
);
    import ttt_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_SCAN} state_t;

    state_t state_reg, state_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [31:0] req_reg [TABLE_DEPTH];
    logic [31:0] bar_reg [TABLE_DEPTH];
    logic [31:0] cid_reg [TABLE_DEPTH];
    logic [63:0] sw_reg [TABLE_DEPTH];
    logic [31:0] exp_reg [TABLE_DEPTH];
    logic [2:0] flg_reg [TABLE_DEPTH];
    logic [31:0] now_reg, now_next;
    in_item_t cur_reg, cur_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [NW-1:0] n_reg, n_next;

    logic [TABLE_DEPTH-1:0] hit_req, hit_bar, hit_rid_req, hit_rid_bar;
    logic any_req, any_bar, any_rr, any_rb, any_free;
    logic [IW-1:0] free_i, rr_i, rb_i;

    // per-entry compares; priority picks lowest index
    always_comb
    begin
        any_req = 1'b0; any_bar = 1'b0; any_rr = 1'b0; any_rb = 1'b0; any_free = 1'b0;
        free_i = '0; rr_i = '0; rb_i = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            hit_req[i] = valid_reg[i] && (req_reg[i] == cur_reg.request_id);
            hit_bar[i] = valid_reg[i] && (bar_reg[i] == cur_reg.barrier_id);
            hit_rid_req[i] = valid_reg[i] && (req_reg[i] == cur_reg.reply_id);
            hit_rid_bar[i] = valid_reg[i] && (bar_reg[i] == cur_reg.reply_id);
        end
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                any_free = 1'b1; free_i = IW'(i);
            end
            if (hit_rid_req[i])
            begin
                any_rr = 1'b1; rr_i = IW'(i);
            end
            if (hit_rid_bar[i])
            begin
                any_rb = 1'b1; rb_i = IW'(i);
            end
        end
        any_req = |hit_req;
        any_bar = |hit_bar;
    end

    logic scan_exp;
    logic [31:0] diff;
    assign diff = exp_reg[idx_reg] - now_reg;
    assign scan_exp = valid_reg[idx_reg] && diff[31];

    // table write controls
    logic wr_open, wr_match, wr_scan;
    logic [IW-1:0] m_i;
    logic m_err_path;
    logic [2:0] kind_c;

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        now_next = now_reg;
        cur_next = cur_reg;
        idx_next = idx_reg;
        n_next = n_reg;
        in_pop = 1'b0;
        out_push = 1'b0;
        out_close = 1'b0;
        out_item = '0;
        wr_open = 1'b0; wr_match = 1'b0; wr_scan = 1'b0;
        m_i = '0; m_err_path = 1'b0; kind_c = K_SUCCESS;
        case (state_reg)
            S_IDLE:
            begin
                if (!in_empty)
                begin
                    in_pop = 1'b1;
                    cur_next = in_item;
                    if (in_item.mode == MODE_TICK)
                    begin
                        now_next = now_reg + 32'd1;
                        idx_next = '0;
                        n_next = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK:
            begin
                if (!out_full)
                begin
                    out_push = 1'b1;
                    out_item.last = 1'b1;
                    state_next = S_IDLE;
                    if (cur_reg.mode == MODE_OPEN)
                    begin
                        out_item.result_switch = cur_reg.switch_id;
                        out_item.result_caller_id = cur_reg.caller_id;
                        if (any_req || any_bar || !any_free)
                        begin
                            out_item.kind = K_REJECT;
                        end
                        else
                        begin
                            out_item.kind = K_OPENED;
                            wr_open = 1'b1;
                            valid_next[free_i] = 1'b1;
                        end
                    end
                    else
                    begin
                        if (cur_reg.mode == MODE_ERROR && any_rr)
                        begin
                            m_i = rr_i; m_err_path = 1'b1;
                        end
                        else
                        begin
                            m_i = rb_i;
                        end
                        if ((cur_reg.mode == MODE_ERROR && any_rr) || any_rb)
                        begin
                            wr_match = 1'b1;
                            out_item.kind = K_MATCHED;
                            out_item.result_switch = sw_reg[m_i];
                            out_item.result_caller_id = cid_reg[m_i];
                        end
                        else
                        begin
                            out_item.kind = K_UNTRACKED;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (n_reg == NW'(MAX_RESULTS))
                begin
                    state_next = S_IDLE;
                end
                else if (scan_exp)
                begin
                    if (!out_full)
                    begin
                        if (flg_reg[idx_reg][0])
                        begin
                            kind_c = flg_reg[idx_reg][1] ? K_FAILURE : K_SUCCESS;
                            valid_next[idx_reg] = 1'b0;
                        end
                        else if (!flg_reg[idx_reg][2])
                        begin
                            kind_c = K_FLUSH;
                            wr_scan = 1'b1;
                        end
                        else
                        begin
                            kind_c = K_FAILURE;
                            valid_next[idx_reg] = 1'b0;
                        end
                        out_push = 1'b1;
                        out_item.kind = kind_c;
                        out_item.result_switch = sw_reg[idx_reg];
                        out_item.result_caller_id = cid_reg[idx_reg];
                        n_next = n_reg + 1'b1;
                        out_item.last = 1'b0;
                        // last when table end reached or result cap hit
                        if (idx_reg == IW'(TABLE_DEPTH - 1)
                            || n_reg == NW'(MAX_RESULTS - 1))
                        begin
                            out_item.last = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                end
                else if (idx_reg == IW'(TABLE_DEPTH - 1))
                begin
                    // end of table: the held result becomes the last one
                    if (n_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (!out_full)
                    begin
                        out_close = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_open)
        begin
            req_reg[free_i] <= cur_reg.request_id;
            bar_reg[free_i] <= cur_reg.barrier_id;
            cid_reg[free_i] <= cur_reg.caller_id;
            sw_reg[free_i] <= cur_reg.switch_id;
            exp_reg[free_i] <= now_reg + {24'd0, timeout_ticks};
            flg_reg[free_i] <= 3'b000;
        end
        if (wr_match)
        begin
            exp_reg[m_i] <= now_reg + {24'd0, margin_ticks};
            if (cur_reg.mode == MODE_REPLY)
            begin
                flg_reg[m_i] <= flg_reg[m_i] | 3'b001;
            end
            else if (m_err_path)
            begin
                flg_reg[m_i] <= flg_reg[m_i] | 3'b010;
            end
            else
            begin
                flg_reg[m_i] <= flg_reg[m_i] | 3'b011;
            end
        end
        if (wr_scan)
        begin
            exp_reg[idx_reg] <= now_reg + {24'd0, margin_ticks};
            flg_reg[idx_reg] <= flg_reg[idx_reg] | 3'b100;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            now_reg <= '0;
            idx_reg <= '0;
            n_reg <= '0;
            cur_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            now_reg <= now_next;
            idx_reg <= idx_next;
            n_reg <= n_next;
            cur_reg <= cur_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/ttt_outq.sv -----
// Output stage: holds each result until its last flag is known, then releases it.
`default_nettype none
module ttt_outq #(
    parameter int DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire ttt_pkg::out_item_t wdata,
    input  wire logic               close,
    output logic                    full,
    input  wire logic               pop,
    output ttt_pkg::out_item_t      rdata,
    output logic                    empty
);
    import ttt_pkg::*;

    // one held result: it is released once the next result, its own last
    // flag or the end of the scan decides its last flag
    out_item_t hold_reg;
    logic hold_v_reg;
    logic q_full, q_empty, q_push;
    out_item_t q_in;

    assign full = hold_v_reg && q_full;
    assign q_push = hold_v_reg && (push || close || hold_reg.last) && !q_full;
    always_comb
    begin
        q_in = hold_reg;
        if (close)
        begin
            q_in.last = 1'b1;
        end
    end

    ttt_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(DEPTH)) u_q (
        .clk(clk), .rst_n(rst_n),
        .push(q_push), .wdata(q_in), .full(q_full),
        .pop(pop), .rdata(rdata), .empty(q_empty)
    );
    assign empty = q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg <= 1'b0;
        end
        else if (push && !full)
        begin
            hold_v_reg <= 1'b1;
        end
        else if (q_push)
        begin
            hold_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            hold_reg <= wdata;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/transaction_tracker_with_timeout.sv -----
// Top level: transaction tracker with timeout.
// Items enter a two-entry input queue and are executed one at a time by the
// table engine. Open, reply and error pass through a take state and a lookup
// state. A tick visits one entry per cycle, stalling on an expired entry while
// the output is full, and gives at most one result per cycle. Each result waits
// in a holding register until the next result, its own last flag or the end of
// the scan settles its last flag, then leaves through a four-entry output queue;
// a full queue stalls the engine.
`default_nettype none
module transaction_tracker_with_timeout #(
    parameter int TABLE_DEPTH = ttt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire ttt_pkg::in_item_t      in_item,
    output logic                        full,
    input  wire logic                   pop,
    output ttt_pkg::out_item_t          out_item,
    output logic                        empty,
    input  wire logic                   cfg_we,
    input  wire logic [ttt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]             cfg_data
);
    import ttt_pkg::*;

    logic [7:0] timeout_reg, margin_reg;
    logic q_empty, q_pop, e_push, e_full, e_close;
    in_item_t q_item;
    out_item_t e_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RST;
            margin_reg <= MARGIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIMEOUT: timeout_reg <= cfg_data;
                REG_MARGIN: margin_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    ttt_fifo #(.WIDTH($bits(in_item_t)), .DEPTH(2)) u_inq (
        .clk(clk), .rst_n(rst_n),
        .push(push), .wdata(in_item), .full(full),
        .pop(q_pop), .rdata(q_item), .empty(q_empty)
    );

    ttt_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_eng (
        .clk(clk), .rst_n(rst_n),
        .timeout_ticks(timeout_reg), .margin_ticks(margin_reg),
        .in_empty(q_empty), .in_item(q_item), .in_pop(q_pop),
        .out_full(e_full), .out_push(e_push), .out_close(e_close), .out_item(e_item)
    );

    ttt_outq #(.DEPTH(4)) u_outq (
        .clk(clk), .rst_n(rst_n),
        .push(e_push), .wdata(e_item), .close(e_close), .full(e_full),
        .pop(pop), .rdata(out_item), .empty(empty)
    );
endmodule
`default_nettype wire
